@@ sv/fqd_pkg.sv @@
// Shared constants, command codes and cell control types for the FIFO queue
// with delete-by-value. No dependencies.
`default_nettype none

package fqd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_CNT_W = 5;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_DELETE  = 2'd2
    } cmd_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic  enq;   // write word into the tail cell
        logic  deq;   // every cell takes its neighbor's word
        logic  del;   // search, then close the gap behind the first hit
        word_t word;
    } fqd_ctrl_t;

    // Per-cell position flags derived from the occupancy count.
    typedef struct packed {
        logic occupied;
        logic tail;
    } fqd_pos_t;

endpackage

`default_nettype wire

@@ sv/fqd_cell.sv @@
// One storage cell of the queue row: holds a word, compares it on delete,
// and shifts toward the head. Depends on fqd_pkg.
`default_nettype none

module fqd_cell (
    input  wire logic              aclk,
    input  wire fqd_pkg::fqd_ctrl_t ctrl,
    input  wire fqd_pkg::fqd_pos_t  pos,
    input  wire fqd_pkg::word_t     next_data,
    input  wire logic              hit_in,
    output logic                   hit_out,
    output fqd_pkg::word_t          data_out
);
    import fqd_pkg::*;

    word_t data_reg;
    word_t data_next;
    logic  match;
    logic  shift;

    assign match    = ctrl.del & pos.occupied & (data_reg == ctrl.word);
    assign hit_out  = hit_in | match;
    // Cells at or behind the first hit close the gap.
    assign shift    = ctrl.deq | (ctrl.del & hit_out);
    assign data_out = data_reg;

    always_comb begin
        if (shift) begin
            data_next = next_data;
        end else if (ctrl.enq & pos.tail) begin
            data_next = ctrl.word;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ sv/fifo_queue_with_delete_core.sv @@
// Top level of the FIFO queue with delete-by-value: a row of fqd_cell
// storage cells, the occupancy counter and the result register.
// Depends on fqd_pkg and fqd_cell.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one request: s_command selects
//   enqueue, dequeue or delete-first-match; s_item_value is the word to append
//   or to search for (bits above DATA_WIDTH are ignored).
//   Result channel (m_valid/m_ready) returns one result per request: m_status
//   (0 ok, 1 full/empty/no match/unused code), m_dequeued_value (head word on
//   a successful dequeue, else zero) and m_entry_count after the request.
// Timing: the result of a request is registered at its accepting edge.
// Throughput: one request per cycle while m_ready is high; the whole operation
//   (parallel compare in every cell, first-hit ripple, shift) completes in the
//   accepting cycle, set by the compare plus the hit chain through the row.
// Stall: the result register holds while m_ready is low; s_ready is high
//   whenever that register is empty or being drained in the same cycle.
// Reset: aresetn (synchronous, active low) empties the queue and the result
//   register. Cell contents are not cleared; only occupied cells are read.
`default_nettype none

module fifo_queue_with_delete_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [fqd_pkg::CMD_W-1:0]   s_command,
    input  wire logic [fqd_pkg::VALUE_W-1:0] s_item_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_status,
    output logic [fqd_pkg::VALUE_W-1:0]      m_dequeued_value,
    output logic [fqd_pkg::ENTRY_CNT_W-1:0]  m_entry_count
);
    import fqd_pkg::*;

    // Occupancy and result registers
    count_t occ_reg, occ_next;
    logic   m_valid_reg, m_valid_next;
    logic   status_reg, status_next;
    logic [VALUE_W-1:0] deq_value_reg, deq_value_next;

    logic      accept;
    logic      full, empty;
    cmd_t      cmd;
    word_t     word;
    fqd_ctrl_t ctrl;

    // Cell row wiring
    fqd_pos_t pos   [DEPTH];
    word_t    data  [DEPTH];
    word_t    nxt   [DEPTH];
    logic     hit   [DEPTH+1];
    logic     found;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign full    = (occ_reg == count_t'(DEPTH));
    assign empty   = (occ_reg == '0);
    assign cmd     = cmd_t'(s_command);
    assign word    = DATA_WIDTH'(s_item_value);

    // Broadcast control, gated so the row only moves on a legal request.
    always_comb begin
        ctrl      = '0;
        ctrl.word = word;
        unique case (cmd)
            CMD_ENQUEUE: ctrl.enq = accept & ~full;
            CMD_DEQUEUE: ctrl.deq = accept & ~empty;
            CMD_DELETE:  ctrl.del = accept;
            default:     ctrl     = ctrl;
        endcase
    end

    assign hit[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign pos[k].occupied = (count_t'(k) < occ_reg);
        assign pos[k].tail     = (count_t'(k) == occ_reg);
        // Last cell recycles its own word; it is beyond the count after a shift.
        if (k == DEPTH - 1) begin : g_last
            assign nxt[k] = data[k];
        end else begin : g_mid
            assign nxt[k] = data[k+1];
        end

        fqd_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pos       (pos[k]),
            .next_data (nxt[k]),
            .hit_in    (hit[k]),
            .hit_out   (hit[k+1]),
            .data_out  (data[k])
        );
    end

    assign found = hit[DEPTH];

    // Result and occupancy update
    always_comb begin
        occ_next       = occ_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        status_next    = status_reg;
        deq_value_next = deq_value_reg;
        if (accept) begin
            m_valid_next   = 1'b1;
            status_next    = 1'b1;
            deq_value_next = '0;
            unique case (cmd)
                CMD_ENQUEUE: begin
                    if (!full) begin
                        occ_next    = occ_reg + count_t'(1);
                        status_next = 1'b0;
                    end
                end
                CMD_DEQUEUE: begin
                    if (!empty) begin
                        occ_next       = occ_reg - count_t'(1);
                        status_next    = 1'b0;
                        deq_value_next = VALUE_W'(data[0]);
                    end
                end
                CMD_DELETE: begin
                    if (found) begin
                        occ_next    = occ_reg - count_t'(1);
                        status_next = 1'b0;
                    end
                end
                default: status_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        deq_value_reg <= deq_value_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_dequeued_value = deq_value_reg;
    assign m_entry_count    = ENTRY_CNT_W'(occ_reg);

endmodule

`default_nettype wire

@@ bench/tb_fifo_queue_with_delete_core.sv @@
// Self-checking bench for fifo_queue_with_delete_core: directed and random
// enqueue/dequeue/delete requests checked against a bit-accurate queue predictor.
// Depends on fqd_pkg and the core RTL (fqd_cell and friends).
`default_nettype none

module tb_fifo_queue_with_delete_core;
    import fqd_pkg::*;

    // Code 3 is not in cmd_t; the core must answer it with an error and no change.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // 711 requests; the limit sits far above what a correct run needs, even with
    // 63% gaps or 63% stalls, so this only trips on a hang.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [VALUE_W-1:0] item_value;
    } queue_request_t;

    typedef struct {
        logic                   status;
        logic [VALUE_W-1:0]     dequeued_value;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } queue_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command    = '0;
    logic [VALUE_W-1:0]     s_item_value = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_status;
    logic [VALUE_W-1:0]     m_dequeued_value;
    logic [ENTRY_CNT_W-1:0] m_entry_count;

    // Requests waiting to be driven, and results owed by the core, oldest first.
    queue_request_t request_backlog[$];
    queue_result_t  owed_results[$];

    // Shadow of the core's storage: index 0 is the head.
    word_t held_words[$];

    // Idle percentages for the current phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    fifo_queue_with_delete_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_item_value     (s_item_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_dequeued_value (m_dequeued_value),
        .m_entry_count    (m_entry_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one request to the shadow queue and returns the result the core owes.
    // Upper value bits beyond DATA_WIDTH are dropped by the word_t cast.
    function automatic queue_result_t apply_request(queue_request_t req);
        queue_result_t res;
        word_t         word;
        int            hit;
        word = word_t'(req.item_value);
        hit  = -1;
        res.status         = 1'b1;
        res.dequeued_value = '0;
        case (req.command)
            CMD_ENQUEUE: begin
                if (held_words.size() < DEPTH) begin
                    held_words.push_back(word);
                    res.status = 1'b0;
                end
            end
            CMD_DEQUEUE: begin
                if (held_words.size() > 0) begin
                    res.dequeued_value = VALUE_W'(held_words.pop_front());
                    res.status = 1'b0;
                end
            end
            CMD_DELETE: begin
                // first match from the head; later words close up in order
                for (int k = 0; k < held_words.size() && hit < 0; k++)
                    if (held_words[k] == word)
                        hit = k;
                if (hit >= 0) begin
                    held_words.delete(hit);
                    res.status = 1'b0;
                end
            end
            default: ;  // unused code: error, queue untouched
        endcase
        res.entry_count = ENTRY_CNT_W'(held_words.size());
        return res;
    endfunction

    task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
        queue_request_t req;
        req.command    = cmd;
        req.item_value = value;
        request_backlog.push_back(req);
    endtask

    // Edge cases: empty queue, both value extremes, duplicates, full queue,
    // delete at tail / middle duplicate / head, delete with no match.
    task automatic add_directed_requests();
        add_request(CMD_DEQUEUE, 32'h1234_5678);   // empty dequeue
        add_request(CMD_DELETE,  32'h0000_0000);   // delete on empty
        add_request(CMD_UNUSED,  32'hFFFF_FFFF);
        add_request(CMD_ENQUEUE, 32'h0000_0000);
        add_request(CMD_ENQUEUE, 32'hFFFF_FFFF);
        add_request(CMD_ENQUEUE, 32'h0000_0007);
        add_request(CMD_ENQUEUE, 32'hA5A5_A5A5);
        add_request(CMD_ENQUEUE, 32'h0000_0007);   // duplicate
        add_request(CMD_ENQUEUE, 32'h5A5A_5A5A);
        for (int k = 6; k < DEPTH; k++)
            add_request(CMD_ENQUEUE, 32'h0100_0000 * k + k);
        add_request(CMD_ENQUEUE, 32'hDEAD_BEEF);   // full
        add_request(CMD_UNUSED,  32'h0000_0000);
        add_request(CMD_DELETE,  32'h0F00_000F);   // tail
        add_request(CMD_DELETE,  32'h0000_0007);   // first of two
        add_request(CMD_DELETE,  32'h0000_0000);   // head
        add_request(CMD_DELETE,  32'h1234_5678);   // no match
        add_request(CMD_DEQUEUE, 32'h0000_0000);
    endtask

    // Random traffic in bursts that lean toward filling, draining or neither,
    // so the queue visits both full and empty. Most values come from a small
    // pool so deletes find matches and duplicates are common.
    task automatic add_random_requests(input int count);
        word_t            pool[8];
        int               lean;
        int               run_left;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [VALUE_W-1:0] value;
        for (int k = 0; k < 8; k++)
            pool[k] = $urandom();
        pool[0] = '0;
        pool[1] = '1;
        run_left = 0;
        lean     = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                lean     = $urandom_range(2);
                run_left = $urandom_range(32, 12);
            end
            run_left--;
            pick = $urandom_range(99);
            case (lean)
                0:       cmd = pick < 70 ? CMD_ENQUEUE : pick < 80 ? CMD_DEQUEUE :
                               pick < 97 ? CMD_DELETE : CMD_UNUSED;
                1:       cmd = pick < 25 ? CMD_ENQUEUE : pick < 60 ? CMD_DEQUEUE :
                               pick < 97 ? CMD_DELETE : CMD_UNUSED;
                default: cmd = pick < 40 ? CMD_ENQUEUE : pick < 65 ? CMD_DEQUEUE :
                               pick < 97 ? CMD_DELETE : CMD_UNUSED;
            endcase
            if ((cmd == CMD_ENQUEUE || cmd == CMD_DELETE) && $urandom_range(99) < 80)
                value = VALUE_W'(pool[$urandom_range(7)]);
            else
                value = $urandom();
            add_request(cmd, value);
        end
    endtask

    // Driver. A request moves when s_valid and s_ready are both high at an
    // edge; the predictor runs right there so owed_results keeps accept order.
    // Each output gets at most one nonblocking write per edge.
    always @(posedge aclk) begin : drive_requests
        queue_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req.command    = s_command;
                req.item_value = s_item_value;
                owed_results.push_back(apply_request(req));
            end
            // slot is free after this edge: either empty or just accepted
            if (!s_valid || s_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = request_backlog.pop_front();
                    s_valid      <= 1'b1;
                    s_command    <= req.command;
                    s_item_value <= req.item_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Random backpressure on m_ready; every accepted result is
    // checked field by field against the oldest owed result.
    always @(posedge aclk) begin : check_results
        queue_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got status %0d value %h count %0d",
                             $time, m_status, m_dequeued_value, m_entry_count);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_status);
                        mismatches++;
                    end
                    if (m_dequeued_value !== want.dequeued_value) begin
                        $display("%0t: dequeued_value mismatch: expected %h, got %h",
                                 $time, want.dequeued_value, m_dequeued_value);
                        mismatches++;
                    end
                    if (m_entry_count !== want.entry_count) begin
                        $display("%0t: entry_count mismatch: expected %0d, got %0d",
                                 $time, want.entry_count, m_entry_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Waits, sampling at the falling edge so all edge updates have landed,
    // until nothing is queued, in flight or owed.
    task automatic wait_until_quiet();
        do
            @(negedge aclk);
        while (request_backlog.size() != 0 || s_valid || owed_results.size() != 0);
    endtask

    // Phases: no idling, sender gaps, receiver stalls, then both at once.
    initial begin
        add_directed_requests();
        add_random_requests(160);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait_until_quiet();

        send_idle_pct  = 63;
        recv_stall_pct = 0;
        add_random_requests(175);
        wait_until_quiet();

        send_idle_pct  = 0;
        recv_stall_pct = 63;
        add_random_requests(175);
        wait_until_quiet();

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        add_random_requests(175);
        wait_until_quiet();

        // with stalls off, the spare DRAIN_CYCLES catch any stray result
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
